// ===== hw/rtl/scdb_pkg.sv =====
// shared types and constants for the sata command descriptor builder
package scdb_pkg;

    typedef enum logic [1:0] {
        OP_IDENTIFY   = 2'd0,
        OP_READ_DMA   = 2'd1,
        OP_WRITE_DMA  = 2'd2,
        OP_PACKET_RD  = 2'd3
    } scdb_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_EMIT
    } scdb_state_t;

    localparam logic [7:0]  ATA_IDENTIFY     = 8'hEC;
    localparam logic [7:0]  ATA_READ_DMA_EXT = 8'h25;
    localparam logic [7:0]  ATA_WRITE_DMA_EXT = 8'h35;
    localparam logic [7:0]  ATA_PACKET       = 8'hA0;
    localparam logic [7:0]  PACKET_FEATURE   = 8'h05;

    localparam int unsigned SECTOR_SHIFT     = 9;
    localparam logic [21:0] SECTOR_BC_FIELD  = 22'd511;
    // packet read byte count is limited to 4 MiB
    localparam logic [15:0] PKT_MAX_SECTORS  = 16'd8192;

    typedef struct packed {
        logic [15:0] rem_after;
        logic [7:0]  take;
        logic        fits;
    } scdb_sec_res_t;

endpackage

// ===== hw/rtl/scdb_sector_unit.sv =====
// shared sector subtract and compare unit used for counting and splitting
module scdb_sector_unit
    import scdb_pkg::*;
#(
    parameter int unsigned SECTORS_PER_ENTRY = 16
)
(
    input  logic [15:0]   rem,
    output scdb_sec_res_t res
);

    localparam logic [16:0] SPE17 = 17'(SECTORS_PER_ENTRY);
    localparam logic [7:0]  SPE8  = 8'(SECTORS_PER_ENTRY);

    logic [16:0] diff;

    always_comb
    begin
        diff          = {1'b0, rem} - SPE17;
        // remainder fits in one entry when rem <= sectors per entry
        res.fits      = diff[16] || (diff[15:0] == 16'd0);
        res.take      = res.fits ? rem[7:0] : SPE8;
        res.rem_after = res.fits ? 16'd0 : diff[15:0];
    end

endmodule

// ===== hw/rtl/sata_command_descriptor_builder.sv =====
// Command descriptor builder. One command transfer comes in on s_axis: tuser
// holds the opcode, tdata the start lba and the sector count. Each scatter
// entry leaves as one transfer on m_axis; tlast marks the final entry and
// tuser flags a refused command, which yields a single entry.
// buffer_base is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, which the block itself does not enforce. Identify, packet
// read and refused commands go from acceptance straight to the emit state, which
// loads their single entry into the output register. A dma read or write first
// counts its entries through the shared sector unit, then emits one entry per
// cycle while the output register is empty or its entry is taken. s_axis_tready
// is high only while the sequencer is idle; the output register lets a new
// command be taken while the last entry of the previous one still waits.
// When m_axis_tready is low a valid entry in the output register holds and
// the sequencer waits to emit the next one. Reset clears the sequencer state,
// the output valid and buffer_base.
module sata_command_descriptor_builder
    import scdb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES       = 64,
    parameter int unsigned SECTORS_PER_ENTRY = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sector[47:0], num_sectors[63:48]
    input  logic [63:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_index[5:0], data_address[69:6], byte_count_field[91:70],
    // ata_command[99:92], is_write[100], is_packet[101], entry_total[108:102],
    // lba[156:109], count_field[172:157], feature_byte[180:173], zero fill
    output logic [183:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // reject[0]
    output logic         m_axis_tuser
);

    localparam logic [16:0] DMA_MAX_SECTORS = 17'(MAX_ENTRIES * SECTORS_PER_ENTRY);
    localparam logic [63:0] STRIDE          = 64'(SECTORS_PER_ENTRY * 512);

    scdb_state_t state_reg, state_next;

    logic [63:0] buffer_base_reg;

    // latched command
    logic [7:0]  cmd_reg;
    logic        wr_reg;
    logic        pkt_reg;
    logic [47:0] lba_reg;
    logic [15:0] count_reg;
    logic [7:0]  feat_reg;
    logic        rej_reg;
    logic        single_reg;
    logic [21:0] single_bc_reg;

    // sequencer datapath
    logic [15:0] rem_reg, rem_next;
    logic [6:0]  n_reg, n_next;
    logic [5:0]  k_reg, k_next;
    logic [63:0] addr_reg, addr_next;

    // output register
    logic         out_valid_reg, out_valid_next;
    logic [5:0]   o_index_reg;
    logic [63:0]  o_addr_reg;
    logic [21:0]  o_bc_reg;
    logic         o_last_reg;
    logic [7:0]   o_cmd_reg;
    logic         o_wr_reg;
    logic         o_pkt_reg;
    logic [6:0]   o_total_reg;
    logic [47:0]  o_lba_reg;
    logic [15:0]  o_count_reg;
    logic [7:0]   o_feat_reg;
    logic         o_rej_reg;

    scdb_sec_res_t sec_res;

    logic        in_xfer;
    logic        load;
    logic        is_last;
    logic [5:0]  e_index;
    logic [63:0] e_addr;
    logic [21:0] e_bc;
    logic [6:0]  e_total;

    scdb_op_t    in_op;
    logic [47:0] in_sector;
    logic [15:0] in_count;

    assign in_op     = scdb_op_t'(s_axis_tuser);
    assign in_sector = s_axis_tdata[47:0];
    assign in_count  = s_axis_tdata[63:48];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    scdb_sector_unit #(
        .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
    ) u_sector_unit (
        .rem (rem_reg),
        .res (sec_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((in_op == OP_READ_DMA || in_op == OP_WRITE_DMA) &&
                        in_count != 16'd0 && {1'b0, in_count} <= DMA_MAX_SECTORS)
                        state_next = ST_COUNT;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_COUNT:
            begin
                if (sec_res.fits)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && is_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_axis_tready  = (state_reg == ST_IDLE);
        load           = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
        is_last        = single_reg || ((7'({1'b0, k_reg}) + 7'd1) == n_reg);
        rem_next       = rem_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (load)
            out_valid_next = 1'b1;

        e_index = rej_reg ? 6'd0 : k_reg;
        e_addr  = rej_reg ? 64'd0 : addr_reg;
        e_total = rej_reg ? 7'd0 : n_reg;
        if (single_reg)
            e_bc = single_bc_reg;
        else
            e_bc = {5'd0, sec_res.take, {SECTOR_SHIFT{1'b0}}} - 22'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rem_next  = in_count;
                    n_next    = (in_op == OP_IDENTIFY || in_op == OP_PACKET_RD) ? 7'd1 : 7'd0;
                    k_next    = 6'd0;
                    addr_next = buffer_base_reg;
                end
            end
            ST_COUNT:
            begin
                n_next   = n_reg + 7'd1;
                rem_next = sec_res.fits ? count_reg : sec_res.rem_after;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    rem_next  = sec_res.rem_after;
                    k_next    = k_reg + 6'd1;
                    addr_next = addr_reg + STRIDE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            buffer_base_reg <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                buffer_base_reg <= cfg_wr_data;
        end
    end

    // command latch and sequencer datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        addr_reg <= addr_next;
        if (in_xfer)
        begin
            count_reg <= in_count;
            unique case (in_op)
                OP_IDENTIFY:
                begin
                    cmd_reg       <= ATA_IDENTIFY;
                    wr_reg        <= 1'b0;
                    pkt_reg       <= 1'b0;
                    lba_reg       <= 48'd0;
                    feat_reg      <= 8'd0;
                    rej_reg       <= 1'b0;
                    single_reg    <= 1'b1;
                    single_bc_reg <= SECTOR_BC_FIELD;
                end
                OP_PACKET_RD:
                begin
                    cmd_reg       <= ATA_PACKET;
                    wr_reg        <= 1'b0;
                    pkt_reg       <= 1'b1;
                    lba_reg       <= {16'd0, in_sector[31:0]};
                    feat_reg      <= PACKET_FEATURE;
                    rej_reg       <= (in_count == 16'd0) || (in_count > PKT_MAX_SECTORS);
                    single_reg    <= 1'b1;
                    single_bc_reg <= {in_count[12:0], {SECTOR_SHIFT{1'b0}}} - 22'd1;
                end
                OP_READ_DMA, OP_WRITE_DMA:
                begin
                    cmd_reg       <= (in_op == OP_READ_DMA) ? ATA_READ_DMA_EXT
                                                            : ATA_WRITE_DMA_EXT;
                    wr_reg        <= (in_op == OP_WRITE_DMA);
                    pkt_reg       <= 1'b0;
                    lba_reg       <= in_sector;
                    feat_reg      <= 8'd0;
                    rej_reg       <= (in_count == 16'd0) ||
                                     ({1'b0, in_count} > DMA_MAX_SECTORS);
                    single_reg    <= (in_count == 16'd0) ||
                                     ({1'b0, in_count} > DMA_MAX_SECTORS);
                    single_bc_reg <= 22'd0;
                end
                default: ;
            endcase
        end
    end

    // count field differs for packet read and identify, derive it at load time
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_index_reg <= e_index;
            o_addr_reg  <= e_addr;
            o_bc_reg    <= rej_reg ? 22'd0 : e_bc;
            o_last_reg  <= is_last;
            o_cmd_reg   <= cmd_reg;
            o_wr_reg    <= wr_reg;
            o_pkt_reg   <= pkt_reg;
            o_total_reg <= e_total;
            o_lba_reg   <= lba_reg;
            if (pkt_reg)
                o_count_reg <= {8'd0, count_reg[7:0]};
            else if (cmd_reg == ATA_IDENTIFY)
                o_count_reg <= 16'd0;
            else
                o_count_reg <= count_reg;
            o_feat_reg  <= feat_reg;
            o_rej_reg   <= rej_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = o_rej_reg;
    assign m_axis_tdata  = {3'd0, o_feat_reg, o_count_reg, o_lba_reg, o_total_reg,
                            o_pkt_reg, o_wr_reg, o_cmd_reg, o_bc_reg, o_addr_reg,
                            o_index_reg};

endmodule

// ===== dv/scdb_entry_checker.sv =====
// scoreboard for the command descriptor builder: predicts and checks every scatter entry
`timescale 1ns / 1ps
module scdb_entry_checker
    import scdb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES       = 64,
    parameter int unsigned SECTORS_PER_ENTRY = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [183:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic         m_axis_tuser,
    output int           mismatch_count,
    output int           entries_owed
);

    typedef struct packed {
        logic [5:0]  index;
        logic [63:0] address;
        logic [21:0] bc_field;
        logic        last;
        logic [7:0]  ata_cmd;
        logic        wr;
        logic        pkt;
        logic [6:0]  total;
        logic [47:0] lba;
        logic [15:0] count;
        logic [7:0]  feature;
        logic        reject;
    } scatter_entry_t;

    localparam logic [63:0] ENTRY_STRIDE = 64'(SECTORS_PER_ENTRY) << SECTOR_SHIFT;

    scatter_entry_t expected_entries[$];
    logic [63:0]    buffer_base;

    // builder state after the last accepted command that was not refused
    logic [5:0]     entries_issued;
    logic [15:0]    sectors_left;
    logic [63:0]    address_after;
    scatter_entry_t command_fields;

    initial
    begin
        mismatch_count = 0;
        entries_owed   = 0;
    end

    task automatic build_descriptors(input scdb_op_t op, input logic [47:0] sector,
                                     input logic [15:0] count);
        scatter_entry_t e;
        int unsigned    n;
        int unsigned    left;
        int unsigned    take;
        logic [63:0]    addr;
        e    = '0;
        left = count;
        addr = buffer_base;
        e.last = 1'b1;
        case (op)
            OP_IDENTIFY:
            begin
                e.ata_cmd  = ATA_IDENTIFY;
                e.total    = 7'd1;
                e.address  = buffer_base;
                e.bc_field = SECTOR_BC_FIELD;
                expected_entries.push_back(e);
                entries_issued = 6'd1;
                sectors_left   = '0;
                address_after  = buffer_base + 64'd512;
                command_fields = e;
            end
            OP_PACKET_RD:
            begin
                e.ata_cmd = ATA_PACKET;
                e.pkt     = 1'b1;
                e.lba     = {16'd0, sector[31:0]};
                e.count   = {8'd0, count[7:0]};
                e.feature = PACKET_FEATURE;
                if (count == 16'd0 || count > PKT_MAX_SECTORS)
                begin
                    e.reject = 1'b1;
                    expected_entries.push_back(e);
                end
                else
                begin
                    e.total    = 7'd1;
                    e.address  = buffer_base;
                    e.bc_field = 22'((32'(count) << SECTOR_SHIFT) - 32'd1);
                    expected_entries.push_back(e);
                    entries_issued = 6'd1;
                    sectors_left   = '0;
                    address_after  = buffer_base + (64'(count) << SECTOR_SHIFT);
                    command_fields = e;
                end
            end
            default:
            begin
                e.ata_cmd = (op == OP_READ_DMA) ? ATA_READ_DMA_EXT : ATA_WRITE_DMA_EXT;
                e.wr      = (op == OP_WRITE_DMA);
                e.lba     = sector;
                e.count   = count;
                n = (left + SECTORS_PER_ENTRY - 1) / SECTORS_PER_ENTRY;
                if (count == 16'd0 || n > MAX_ENTRIES)
                begin
                    e.reject = 1'b1;
                    expected_entries.push_back(e);
                end
                else
                begin
                    e.total = 7'(n);
                    for (int unsigned k = 0; k < n; k++)
                    begin
                        take       = (left < SECTORS_PER_ENTRY) ? left : SECTORS_PER_ENTRY;
                        e.index    = 6'(k);
                        e.address  = addr;
                        e.bc_field = 22'((take << SECTOR_SHIFT) - 1);
                        e.last     = (k + 1 == n);
                        expected_entries.push_back(e);
                        left -= take;
                        addr += ENTRY_STRIDE;
                    end
                    entries_issued = 6'(n);
                    sectors_left   = 16'(left);
                    address_after  = addr;
                    command_fields = e;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%t mismatch in %s: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scatter_entry_t want;
        if (!rst_n)
        begin
            buffer_base    = '0;
            entries_issued = '0;
            sectors_left   = '0;
            address_after  = '0;
            command_fields = '0;
            expected_entries.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_entries.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%t unexpected entry transfer, tdata %h", $realtime,
                                 m_axis_tdata);
                end
                else
                begin
                    want = expected_entries.pop_front();
                    check_field("entry_index",      64'(want.index),    64'(m_axis_tdata[5:0]));
                    check_field("data_address",     want.address,       m_axis_tdata[69:6]);
                    check_field("byte_count_field", 64'(want.bc_field), 64'(m_axis_tdata[91:70]));
                    check_field("last",             64'(want.last),     64'(m_axis_tlast));
                    check_field("ata_command",      64'(want.ata_cmd),  64'(m_axis_tdata[99:92]));
                    check_field("is_write",         64'(want.wr),       64'(m_axis_tdata[100]));
                    check_field("is_packet",        64'(want.pkt),      64'(m_axis_tdata[101]));
                    check_field("entry_total",      64'(want.total),    64'(m_axis_tdata[108:102]));
                    check_field("lba",              64'(want.lba),      64'(m_axis_tdata[156:109]));
                    check_field("count_field",      64'(want.count),    64'(m_axis_tdata[172:157]));
                    check_field("feature_byte",     64'(want.feature),  64'(m_axis_tdata[180:173]));
                    check_field("reject",           64'(want.reject),   64'(m_axis_tuser));
                end
            end
            if (cfg_wr_en)
                buffer_base = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                build_descriptors(scdb_op_t'(s_axis_tuser), s_axis_tdata[47:0],
                                  s_axis_tdata[63:48]);
        end
        entries_owed = expected_entries.size();
    end

endmodule

// ===== dv/testbench.sv =====
// stimulus and verdict for the command descriptor builder
`timescale 1ns / 1ps
module testbench;
    import scdb_pkg::*;

    localparam int unsigned IDLE_PERCENT = 18;
    localparam int          HOLD_CYCLES  = 400;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic [63:0]  cfg_wr_data   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [183:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;
    int           mismatch_count;
    int           entries_owed;

    logic         gaps_on    = 1'b1;
    logic         calm       = 1'b0;
    logic         hold_req   = 1'b0;
    logic         hold_spent = 1'b0;
    int           hold_left  = 0;

    always #4 clk = ~clk;

    sata_command_descriptor_builder uut (.*);

    scdb_entry_checker entry_check (.*);

    // sink side: random back-pressure, always ready when calm, one long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req && !hold_spent)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_spent    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic write_base(input logic [63:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_command(input scdb_op_t op, input logic [47:0] sector,
                                input logic [15:0] count);
        int unsigned gap;
        if (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {count, sector};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // wait for every predicted entry, then idle before the next phase
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (entries_owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // most counts stay small; boundaries around entry and packet limits get extra weight
    function automatic logic [15:0] pick_count(input scdb_op_t op);
        int unsigned roll;
        roll = $urandom_range(99);
        case (op)
            OP_IDENTIFY:
                return 16'($urandom);
            OP_PACKET_RD:
            begin
                if (roll < 60)
                    return 16'($urandom_range(1, 300));
                else if (roll < 80)
                    return 16'($urandom_range(1, 8192));
                else if (roll < 88)
                    return 16'($urandom_range(8190, 8194));
                else if (roll < 92)
                    return 16'd0;
                else
                    return 16'($urandom);
            end
            default:
            begin
                if (roll < 50)
                    return 16'($urandom_range(1, 64));
                else if (roll < 72)
                    return 16'($urandom_range(65, 1024));
                else if (roll < 82)
                    return 16'($urandom_range(1, 65) * 16 - 1 + $urandom_range(0, 2));
                else if (roll < 87)
                    return 16'd0;
                else
                    return 16'($urandom);
            end
        endcase
    endfunction

    task automatic random_commands(input int n);
        scdb_op_t op;
        repeat (n)
        begin
            op = scdb_op_t'($urandom_range(3));
            send_command(op, 48'({$urandom(), $urandom()}), pick_count(op));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base('0);
        send_command(OP_IDENTIFY,  48'd0,              16'd0);
        send_command(OP_IDENTIFY,  48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_command(OP_READ_DMA,  48'd0,              16'd1);
        send_command(OP_READ_DMA,  48'hFFFF_FFFF_FFFF, 16'd15);
        send_command(OP_READ_DMA,  48'h1234_5678_9ABC, 16'd16);
        send_command(OP_READ_DMA,  48'h0000_0001_0000, 16'd17);
        send_command(OP_READ_DMA,  48'h8000_0000_0001, 16'd1024);
        send_command(OP_READ_DMA,  48'd0,              16'd1025);
        send_command(OP_READ_DMA,  48'd0,              16'd0);
        send_command(OP_READ_DMA,  48'd0,              16'hFFFF);
        send_command(OP_WRITE_DMA, 48'hFFFF_FFFF_FFFF, 16'd1);
        send_command(OP_WRITE_DMA, 48'hA5A5_5A5A_0F0F, 16'd33);
        send_command(OP_WRITE_DMA, 48'h5A5A_A5A5_F0F0, 16'd1024);
        send_command(OP_WRITE_DMA, 48'h0000_0000_0100, 16'd1025);
        send_command(OP_WRITE_DMA, 48'd0,              16'd0);
        send_command(OP_PACKET_RD, 48'hFFFF_FFFF_FFFF, 16'd1);
        send_command(OP_PACKET_RD, 48'h1234_8765_4321, 16'd255);
        send_command(OP_PACKET_RD, 48'd0,              16'd256);
        send_command(OP_PACKET_RD, 48'hFEDC_BA98_7654, 16'd8192);
        send_command(OP_PACKET_RD, 48'd0,              16'd8193);
        send_command(OP_PACKET_RD, 48'd0,              16'd0);
        send_command(OP_PACKET_RD, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        drain();

        // all-ones base wraps every entry address after the first past zero
        write_base('1);
        random_commands(30);
        drain();

        calm    <= 1'b1;
        gaps_on  = 1'b0;
        write_base({$urandom(), $urandom()});
        random_commands(30);
        drain();
        calm    <= 1'b0;
        gaps_on  = 1'b1;

        write_base(64'hFFFF_FFFF_FFF0_0000);
        hold_req <= 1'b1;
        random_commands(30);
        drain();

        write_base({$urandom(), $urandom()});
        random_commands(40);
        drain();

        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && entries_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/scdb_pkg.sv
hw/rtl/scdb_sector_unit.sv
hw/rtl/sata_command_descriptor_builder.sv
dv/scdb_entry_checker.sv
dv/testbench.sv
